>>> rtl/core/ssm_pkg.sv
`default_nettype none

package ssm_pkg;

  // Default store depths
  localparam int KEY_SPACE_DEF   = 1024;
  localparam int DENSE_DEPTH_DEF = 256;

  // Field widths
  localparam int OPCODE_W    = 2;
  localparam int KEY_W       = 10;
  localparam int STATUS_W    = 3;
  localparam int SLOT_W      = 8;
  localparam int COUNT_W     = 9;
  localparam int MAX_KEY_W   = 10;
  localparam int LIMIT_W     = 9;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 24;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEY     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSE_LIMIT = 1'b1;

  // Register reset values
  localparam logic [MAX_KEY_W-1:0] MAX_KEY_RST     = 10'd1023;
  localparam logic [LIMIT_W-1:0]   DENSE_LIMIT_RST = 9'd256;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_FULL    = 3'd2,
    ST_PRESENT = 3'd3,
    ST_ABSENT  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE    = 2'd0,
    CS_SLOT    = 2'd1,
    CS_RESOLVE = 2'd2
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;     // capture item, read key store and last slot
    logic rd_slot;  // hold last key, read slot store at found slot
    logic commit;   // write back, update count, load result
  } ssm_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_busy; // result register holds a transfer not yet taken
  } ssm_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/sparse_set_membership_top.sv
// Sparse set of small keys with lookup, insert, delete and clear.
// Each item goes through dependent reads of the key store, then the slot store, then
// the write-back of both, which also loads the result register and waits while it
// holds an untaken result; a new item is taken only after that write-back.
// Reset (rst_n low, synchronous) empties the set and restores the registers;
// the stores are not cleared and need no clearing pass.
`default_nettype none

module sparse_set_membership_top #(
  parameter int KEY_SPACE   = ssm_pkg::KEY_SPACE_DEF,
  parameter int DENSE_DEPTH = ssm_pkg::DENSE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Input item
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [ssm_pkg::IN_TDATA_W-1:0]   in_tdata,  // key[9:0], zero pad
  input  wire logic [ssm_pkg::OPCODE_W-1:0]     in_tuser,  // opcode[1:0]
  // Result item
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [ssm_pkg::OUT_TDATA_W-1:0]       out_tdata, // status[2:0], slot[10:3],
                                                           // member_count[19:11], zero pad
  // Configuration
  input  wire logic                             cfg_we,
  input  wire logic [ssm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ssm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ssm_pkg::*;

  ssm_cmd_t            cmd;
  ssm_sts_t            sts;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [COUNT_W-1:0]  out_count;

  ssm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssm_datapath #(
    .KEY_SPACE   (KEY_SPACE),
    .DENSE_DEPTH (DENSE_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_opcode  (in_tuser),
    .in_key     (in_tdata[KEY_W-1:0]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_count  (out_count)
  );

  // Pack the result fields, lowest first
  assign out_tdata = {{(OUT_TDATA_W - STATUS_W - SLOT_W - COUNT_W){1'b0}},
                      out_count, out_slot, out_status};

endmodule

`default_nettype wire

>>> rtl/core/ssm_ctrl.sv
`default_nettype none

module ssm_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire ssm_pkg::ssm_sts_t sts,
  output ssm_pkg::ssm_cmd_t      cmd
);
  import ssm_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_IDLE: begin
        if (in_tvalid) begin
          state_nxt = CS_SLOT;
        end
      end
      CS_SLOT: begin
        state_nxt = CS_RESOLVE;
      end
      CS_RESOLVE: begin
        if (!sts.out_busy) begin
          state_nxt = CS_IDLE;
        end
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_tready   = 1'b0;
    cmd.load    = 1'b0;
    cmd.rd_slot = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      CS_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      CS_SLOT: begin
        cmd.rd_slot = 1'b1;
      end
      CS_RESOLVE: begin
        cmd.commit = !sts.out_busy;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // At most one command per cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.rd_slot, cmd.commit}))
    else $error("ssm_ctrl: overlapping commands");

  // A captured item always proceeds to the slot read
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.rd_slot)
    else $error("ssm_ctrl: load not followed by slot read");

  // After the write-back the input side is open again
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> in_tready)
    else $error("ssm_ctrl: input not ready after commit");

endmodule

`default_nettype wire

>>> rtl/core/ssm_datapath.sv
`default_nettype none

module ssm_datapath #(
  parameter int KEY_SPACE   = ssm_pkg::KEY_SPACE_DEF,
  parameter int DENSE_DEPTH = ssm_pkg::DENSE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire ssm_pkg::ssm_cmd_t            cmd,
  output ssm_pkg::ssm_sts_t                 sts,
  input  wire logic [ssm_pkg::OPCODE_W-1:0] in_opcode,
  input  wire logic [ssm_pkg::KEY_W-1:0]    in_key,
  input  wire logic                         cfg_we,
  input  wire logic [ssm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [ssm_pkg::STATUS_W-1:0]      out_status,
  output logic [ssm_pkg::SLOT_W-1:0]        out_slot,
  output logic [ssm_pkg::COUNT_W-1:0]       out_count
);
  import ssm_pkg::*;

  localparam int KW = $clog2(KEY_SPACE);
  localparam int SW = $clog2(DENSE_DEPTH);
  localparam int CW = $clog2(DENSE_DEPTH + 1);

  // Configuration registers
  logic [MAX_KEY_W-1:0] max_key_r;
  logic [LIMIT_W-1:0]   dense_limit_r;

  // Item registers
  opcode_t          op_r;
  logic [KEY_W-1:0] key_r;
  logic             key_ok_r;
  logic [KW-1:0]    last_key_r;
  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;

  // Stores
  logic [SW-1:0] k2s_mem [KEY_SPACE];
  logic [KW-1:0] s2k_mem [DENSE_DEPTH];
  logic [SW-1:0] k2s_rd_r;
  logic [KW-1:0] s2k_rd_r;
  logic [SW-1:0] s2k_raddr;
  logic          s2k_re;

  // Write-back controls
  logic          k2s_we;
  logic [KW-1:0] k2s_waddr;
  logic [SW-1:0] k2s_wdata;
  logic          s2k_we;
  logic [KW-1:0] s2k_wdata;
  logic [SW-1:0] s2k_waddr;

  // Result
  status_t       res_status;
  logic [SW-1:0] res_slot;
  logic          found;
  logic          full;

  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [COUNT_W-1:0]  out_count_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_key_r     <= MAX_KEY_RST;
      dense_limit_r <= DENSE_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_KEY:     max_key_r     <= cfg_wdata[MAX_KEY_W-1:0];
        CFG_DENSE_LIMIT: dense_limit_r <= cfg_wdata[LIMIT_W-1:0];
        default: begin
          max_key_r <= max_key_r;
        end
      endcase
    end
  end

  // Capture the item and its range check
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= opcode_t'(in_opcode);
      key_r    <= in_key;
      key_ok_r <= (in_key <= max_key_r) && (32'(in_key) < 32'(KEY_SPACE));
    end
    if (cmd.rd_slot) begin
      last_key_r <= s2k_rd_r;
    end
  end

  // Key-to-slot store: read at the incoming key
  always_ff @(posedge clk) begin
    if (k2s_we) begin
      k2s_mem[k2s_waddr] <= k2s_wdata;
    end
    if (cmd.load) begin
      k2s_rd_r <= k2s_mem[KW'(in_key)];
    end
  end

  // Slot-to-key store: read the last member first, then the candidate slot
  assign s2k_re    = cmd.load | cmd.rd_slot;
  assign s2k_raddr = cmd.load ? SW'(count_r - CW'(1)) : k2s_rd_r;

  always_ff @(posedge clk) begin
    if (s2k_we) begin
      s2k_mem[s2k_waddr] <= s2k_wdata;
    end
    if (s2k_re) begin
      s2k_rd_r <= s2k_mem[s2k_raddr];
    end
  end

  // Membership cross-check and capacity
  assign found = (32'(k2s_rd_r) < 32'(count_r)) && (s2k_rd_r == KW'(key_r));
  assign full  = (32'(count_r) >= 32'(dense_limit_r)) ||
                 (32'(count_r) >= 32'(DENSE_DEPTH));

  // Resolve the operation
  always_comb begin
    res_status = ST_OK;
    res_slot   = '0;
    count_nxt  = count_r;
    k2s_we     = 1'b0;
    k2s_waddr  = KW'(key_r);
    k2s_wdata  = SW'(count_r);
    s2k_we     = 1'b0;
    s2k_waddr  = SW'(count_r);
    s2k_wdata  = KW'(key_r);
    case (op_r)
      OP_CLEAR: begin
        count_nxt = '0;
      end
      OP_LOOKUP: begin
        if (!key_ok_r) begin
          res_status = ST_RANGE;
        end else if (found) begin
          res_slot = k2s_rd_r;
        end else begin
          res_status = ST_ABSENT;
        end
      end
      OP_INSERT: begin
        if (!key_ok_r) begin
          res_status = ST_RANGE;
        end else if (full) begin
          res_status = ST_FULL;
        end else if (found) begin
          res_status = ST_PRESENT;
        end else begin
          k2s_we    = cmd.commit;
          s2k_we    = cmd.commit;
          res_slot  = SW'(count_r);
          count_nxt = count_r + CW'(1);
        end
      end
      OP_DELETE: begin
        if (!key_ok_r) begin
          res_status = ST_RANGE;
        end else if (!found) begin
          res_status = ST_ABSENT;
        end else begin
          // move the last member into the freed slot
          s2k_we    = cmd.commit;
          s2k_waddr = k2s_rd_r;
          s2k_wdata = last_key_r;
          k2s_we    = cmd.commit;
          k2s_waddr = last_key_r;
          k2s_wdata = k2s_rd_r;
          res_slot  = k2s_rd_r;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // Member count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // Result register: load on commit, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_slot_r   <= SLOT_W'(res_slot);
      out_count_r  <= COUNT_W'(count_nxt);
    end
  end

  assign sts.out_busy = out_valid_r && !out_ready;
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_slot     = out_slot_r;
  assign out_count    = out_count_r;

  // Count stays within the packed store
  assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= 32'(DENSE_DEPTH))
    else $error("ssm_datapath: count beyond store depth");

  // No commit overwrites a result still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && !out_ready))
    else $error("ssm_datapath: result overwritten");

  // A pending result reports the current count
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_count_r == COUNT_W'(count_r)))
    else $error("ssm_datapath: result count differs from count");

endmodule

`default_nettype wire

>>> tb/ssm_checker.sv
`timescale 1ns / 1ps

module ssm_checker
  import ssm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [IN_TDATA_W-1:0]      in_tdata,   // key[9:0], zero pad
  input  logic [OPCODE_W-1:0]        in_tuser,   // opcode[1:0]
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic [OUT_TDATA_W-1:0]     out_tdata,  // status[2:0], slot[10:3],
                                                 // member_count[19:11], zero pad
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata,
  output int                         pending,
  output int                         fail_count,
  output logic [KEY_SPACE_DEF-1:0]   key_written
);

  localparam logic [COUNT_W-1:0] STORE_DEPTH = COUNT_W'(DENSE_DEPTH_DEF);

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [COUNT_W-1:0]   member_count;
  } set_result_t;

  // Shadow copy of the set and its limits
  logic [SLOT_W-1:0]    key_to_slot [KEY_SPACE_DEF];
  logic [KEY_W-1:0]     slot_to_key [DENSE_DEPTH_DEF];
  logic [COUNT_W-1:0]   members;
  logic [MAX_KEY_W-1:0] max_key;
  logic [LIMIT_W-1:0]   dense_limit;
  set_result_t          expected_results [$];

  initial begin
    foreach (key_to_slot[i]) key_to_slot[i] = '0;
    foreach (slot_to_key[i]) slot_to_key[i] = '0;
  end

  // Apply one operation to the shadow set and return the result it yields
  function automatic set_result_t predict_set_op(opcode_t op, logic [KEY_W-1:0] key);
    set_result_t          res;
    logic [SLOT_W-1:0]    found_slot;
    logic [SLOT_W-1:0]    last_slot;
    logic [KEY_W-1:0]     last_key;
    logic [COUNT_W-1:0]   capacity;
    logic                 hit;
    res.status = ST_OK;
    res.slot   = '0;
    capacity   = (dense_limit > STORE_DEPTH) ? STORE_DEPTH : dense_limit;
    // a key is a member only when both stores agree
    found_slot = key_to_slot[key];
    hit        = (found_slot < members) && (slot_to_key[found_slot] == key);
    if (op == OP_CLEAR) begin
      members = '0;
    end else if (key > max_key) begin
      res.status = ST_RANGE;
    end else begin
      case (op)
        OP_LOOKUP: begin
          if (hit) res.slot = found_slot;
          else res.status = ST_ABSENT;
        end
        OP_INSERT: begin
          // full wins over already present
          if (members >= capacity) begin
            res.status = ST_FULL;
          end else if (hit) begin
            res.status = ST_PRESENT;
          end else begin
            slot_to_key[members[SLOT_W-1:0]] = key;
            key_to_slot[key] = members[SLOT_W-1:0];
            res.slot = members[SLOT_W-1:0];
            members  = members + 1'b1;
          end
        end
        OP_DELETE: begin
          if (!hit) begin
            res.status = ST_ABSENT;
          end else begin
            // move the last member into the freed slot
            last_slot = members[SLOT_W-1:0] - 1'b1;
            last_key  = slot_to_key[last_slot];
            slot_to_key[found_slot] = last_key;
            key_to_slot[last_key]   = found_slot;
            members  = members - 1'b1;
            res.slot = found_slot;
          end
        end
        default: ;
      endcase
    end
    res.member_count = members;
    return res;
  endfunction

  // Track register writes, predict on input transfers, compare on result transfers
  always @(posedge clk) begin : track
    set_result_t want;
    set_result_t got;
    int          errs;
    errs = 0;
    if (!rst_n) begin
      members     = '0;
      max_key     = MAX_KEY_RST;
      dense_limit = DENSE_LIMIT_RST;
      expected_results.delete();
      key_written <= '0;
      fail_count  <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_KEY:     max_key     = cfg_wdata[MAX_KEY_W-1:0];
          CFG_DENSE_LIMIT: dense_limit = cfg_wdata[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = predict_set_op(opcode_t'(in_tuser), in_tdata[KEY_W-1:0]);
        expected_results.push_back(want);
        if (opcode_t'(in_tuser) == OP_INSERT && want.status == ST_OK)
          key_written[in_tdata[KEY_W-1:0]] <= 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got.status       = status_t'(out_tdata[STATUS_W-1:0]);
        got.slot         = out_tdata[STATUS_W +: SLOT_W];
        got.member_count = out_tdata[STATUS_W+SLOT_W +: COUNT_W];
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d slot %0d member_count %0d",
                 got.status, got.slot, got.member_count);
          errs++;
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            errs++;
          end
          if (got.slot != want.slot) begin
            $error("slot mismatch: expected %0d, actual %0d", want.slot, got.slot);
            errs++;
          end
          if (got.member_count != want.member_count) begin
            $error("member_count mismatch: expected %0d, actual %0d",
                   want.member_count, got.member_count);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    pending <= expected_results.size();
  end

endmodule

>>> tb/tb_sparse_set_membership_top.sv
`timescale 1ns / 1ps

module tb_sparse_set_membership_top;
  import ssm_pkg::*;

  localparam int     CLK_HALF_NS  = 6;
  localparam int     RESET_CYCLES = 4;
  localparam int     MAX_GAP      = 18;
  localparam int     SETTLE_CYCLES = 8;
  localparam longint RUN_LIMIT_NS = 64'd5_000_000;

  logic                     clk       = 1'b0;
  logic                     rst_n     = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_TDATA_W-1:0]    in_tdata  = '0;   // key[9:0], zero pad
  logic [OPCODE_W-1:0]      in_tuser  = '0;   // opcode[1:0]
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]   out_tdata;        // status[2:0], slot[10:3],
                                              // member_count[19:11], zero pad
  logic                     cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

  int                       pending;
  int                       fail_count;
  logic [KEY_SPACE_DEF-1:0] key_written;
  bit                       idle_off = 1'b0;

  always #(CLK_HALF_NS) clk = ~clk;

  sparse_set_membership_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  ssm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .pending     (pending),
    .fail_count  (fail_count),
    .key_written (key_written)
  );

  function automatic int draw_gap();
    return idle_off ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(opcode_t op, logic [KEY_W-1:0] key);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'(key);
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold off new items until every result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Write both registers back to back; only called while the set is idle
  task automatic set_limits(logic [CFG_DATA_W-1:0] key_cap, logic [CFG_DATA_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_KEY;
    cfg_wdata <= key_cap;
    @(posedge clk);
    cfg_index <= CFG_DENSE_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random operations over keys 0..key_hi (now and then an insert anywhere) with the given mix in percent
  task automatic run_phase(int n_items, int key_hi, int ins_pct, int del_pct, int clr_pct);
    int                roll;
    int                tries;
    opcode_t           op;
    logic [KEY_W-1:0]  key;
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      key  = KEY_W'($urandom_range(0, key_hi));
      if (roll < clr_pct) begin
        op = OP_CLEAR;
      end else if (roll < clr_pct + ins_pct) begin
        op = OP_INSERT;
      end else begin
        op = (roll < clr_pct + ins_pct + del_pct) ? OP_DELETE : OP_LOOKUP;
        // lookups and deletes only touch keys whose store entry exists
        tries = 0;
        while (!key_written[key] && tries < 24) begin
          key = KEY_W'($urandom_range(0, key_hi));
          tries++;
        end
        if (!key_written[key]) op = OP_INSERT;
      end
      // now and then an insert anywhere in the key field
      if (op == OP_INSERT && $urandom_range(0, 9) == 0)
        key = KEY_W'($urandom_range(0, KEY_SPACE_DEF - 1));
      send_item(op, key);
    end
  endtask

  // Result side: random stall before each transfer
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Stimulus and verdict
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    set_limits(CFG_DATA_W'(MAX_KEY_RST), CFG_DATA_W'(DENSE_LIMIT_RST));

    // Basic membership, stale entries, delete of a middle and of the last member
    send_item(OP_INSERT, 10'd0);
    send_item(OP_INSERT, 10'd1023);
    send_item(OP_INSERT, 10'd0);
    send_item(OP_LOOKUP, 10'd0);
    send_item(OP_LOOKUP, 10'd1023);
    send_item(OP_DELETE, 10'd0);
    send_item(OP_LOOKUP, 10'd1023);
    send_item(OP_LOOKUP, 10'd0);
    send_item(OP_DELETE, 10'd0);
    send_item(OP_INSERT, 10'd682);
    send_item(OP_INSERT, 10'd341);
    send_item(OP_CLEAR, 10'd1023);
    send_item(OP_LOOKUP, 10'd1023);
    send_item(OP_DELETE, 10'd682);
    send_item(OP_INSERT, 10'd341);
    send_item(OP_DELETE, 10'd341);

    // Smallest limits: range rejects come before the full check
    drain_results();
    set_limits('0, '0);
    send_item(OP_INSERT, 10'd0);
    send_item(OP_LOOKUP, 10'd1023);
    send_item(OP_DELETE, 10'd1023);
    send_item(OP_INSERT, 10'd1023);

    // Full insert reported even for a key already present
    drain_results();
    set_limits(10'd1023, 10'd1);
    send_item(OP_INSERT, 10'd5);
    send_item(OP_INSERT, 10'd5);
    send_item(OP_INSERT, 10'd6);
    send_item(OP_LOOKUP, 10'd5);

    // Fill to the store depth with a limit above it
    drain_results();
    set_limits(10'd1023, 10'd511);
    run_phase(350, 1023, 95, 2, 0);

    // Limit written with its upper pad bit set, set above the new limit
    drain_results();
    idle_off = 1'b1;
    set_limits(10'd1023, 10'h2FF);
    run_phase(25, 1023, 20, 60, 0);

    // Lowered key range with members left above it
    drain_results();
    idle_off = 1'b0;
    set_limits(10'd63, 10'd40);
    run_phase(30, 80, 35, 35, 5);

    drain_results();
    set_limits(10'd0, 10'd2);
    run_phase(20, 3, 40, 30, 10);

    drain_results();
    idle_off = 1'b1;
    set_limits(10'd1023, 10'd3);
    run_phase(25, 15, 45, 25, 10);

    drain_results();
    idle_off = 1'b0;
    set_limits(10'd511, 10'd256);
    run_phase(25, 600, 50, 25, 5);

    drain_results();
    set_limits(10'd1023, 10'd0);
    run_phase(10, 1023, 60, 20, 0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS sparse_set_membership_top");
    end else begin
      $display("FAIL sparse_set_membership_top");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAIL sparse_set_membership_top");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/ssm_pkg.sv
rtl/core/ssm_ctrl.sv
rtl/core/ssm_datapath.sv
rtl/core/sparse_set_membership_top.sv
tb/ssm_checker.sv
tb/tb_sparse_set_membership_top.sv
